>>> rtl/mrhm_pkg.sv
// shared types, codes and the bytewise crc-16 step for the modbus rtu
// read-holding-registers master; no dependencies
package mrhm_pkg;

   // largest register count a single read may ask for
   localparam int MAX_REGISTERS = 125;

   // input op codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_REPLY   = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_TOO_BIG  = 3'd1;
   localparam logic [2:0] STAT_TIMEOUT  = 3'd2;
   localparam logic [2:0] STAT_CRC_ERR  = 3'd3;
   localparam logic [2:0] STAT_HDR_ERR  = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_SLAVE_ADDRESS     = 3'd0;
   localparam logic [2:0] CSR_FIRST_REGISTER    = 3'd1;
   localparam logic [2:0] CSR_REGISTER_COUNT    = 3'd2;
   localparam logic [2:0] CSR_RESPONSE_CAPACITY = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_TICKS     = 3'd4;

   // protocol constants
   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [19:0] TICKS_MAX         = 20'hFFFFF;

   // configuration register set
   typedef struct packed {
      logic [7:0]  slave_address;
      logic [15:0] first_register;
      logic [6:0]  register_count;
      logic [7:0]  response_capacity;
      logic [19:0] timeout_ticks;
   } cfg_type;

   // what the output stage has to emit for one accepted item
   typedef enum logic [1:0] {
      JOB_REQUEST      = 2'd0,
      JOB_REPLY        = 2'd1,
      JOB_REPLY_STATUS = 2'd2,
      JOB_STATUS       = 2'd3
   } job_mode_type;

   typedef struct packed {
      job_mode_type mode;
      logic [7:0]   data;
      logic [7:0]   index;
      logic [2:0]   status;
      logic [7:0]   slave_address;
      logic [15:0]  first_register;
      logic [6:0]   register_count;
   } job_type;

   // reflected crc-16 over one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/mrhm_ctrl.sv
// transaction control: reply tracking, running crc, header check and timeout
// depends on mrhm_pkg
module mrhm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept_i,
   input  logic [1:0]       op_i,
   input  logic [7:0]       rx_byte_i,
   input  mrhm_pkg::cfg_type cfg_i,
   output logic             job_valid_o,
   output mrhm_pkg::job_type job_o
);
   import mrhm_pkg::*;

   logic        waiting_ff, waiting_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        header_good_ff, header_good_in;
   logic [19:0] elapsed_ff, elapsed_in;
   logic [7:0]  frame_ff, frame_in;

   logic [8:0]  expected;
   logic        size_bad;
   logic [8:0]  idx_plus2;
   logic [8:0]  idx_plus1;
   logic [19:0] elapsed_next;

   // expected reply length and capacity check
   assign expected  = 9'd5 + {1'b0, cfg_i.register_count, 1'b0};
   assign size_bad  = (cfg_i.register_count > 7'(MAX_REGISTERS))
                      || ({1'b0, cfg_i.response_capacity} < expected);
   assign idx_plus2 = {1'b0, count_ff} + 9'd2;
   assign idx_plus1 = {1'b0, count_ff} + 9'd1;
   assign elapsed_next = (elapsed_ff < TICKS_MAX) ? elapsed_ff + 20'd1 : elapsed_ff;

   // next state and job for the item being accepted
   always_comb begin
      waiting_in     = waiting_ff;
      crc_in         = crc_ff;
      count_in       = count_ff;
      crc_low_in     = crc_low_ff;
      header_good_in = header_good_ff;
      elapsed_in     = elapsed_ff;
      frame_in       = frame_ff;
      job_valid_o    = 1'b0;
      job_o.mode           = JOB_STATUS;
      job_o.data           = 8'h00;
      job_o.index          = 8'h00;
      job_o.status         = STAT_OK;
      job_o.slave_address  = cfg_i.slave_address;
      job_o.first_register = cfg_i.first_register;
      job_o.register_count = cfg_i.register_count;
      if (accept_i) begin
         case (op_i)
            OP_START: begin
               waiting_in     = 1'b0;
               crc_in         = CRC_INIT;
               count_in       = 8'h00;
               crc_low_in     = 8'h00;
               header_good_in = 1'b1;
               elapsed_in     = 20'h00000;
               frame_in       = 8'h00;
               job_valid_o    = 1'b1;
               if (size_bad) begin
                  job_o.status = STAT_TOO_BIG;
               end else begin
                  job_o.mode = JOB_REQUEST;
                  waiting_in = 1'b1;
                  frame_in   = expected[7:0];
               end
            end
            OP_BYTE: begin
               if (waiting_ff && (count_ff < frame_ff)) begin
                  // header bytes must match address and function code
                  if ((count_ff == 8'd0) && (rx_byte_i != cfg_i.slave_address)) begin
                     header_good_in = 1'b0;
                  end
                  if ((count_ff == 8'd1) && (rx_byte_i != FUNC_READ_HOLDING)) begin
                     header_good_in = 1'b0;
                  end
                  // crc over the body, keep the low crc byte
                  if (idx_plus2 < {1'b0, frame_ff}) begin
                     crc_in = crc_byte(crc_ff, rx_byte_i);
                  end else if (idx_plus2 == {1'b0, frame_ff}) begin
                     crc_low_in = rx_byte_i;
                  end
                  count_in    = idx_plus1[7:0];
                  job_valid_o = 1'b1;
                  job_o.data  = rx_byte_i;
                  job_o.index = count_ff;
                  if (idx_plus1 == {1'b0, frame_ff}) begin
                     job_o.mode = JOB_REPLY_STATUS;
                     waiting_in = 1'b0;
                     if ({rx_byte_i, crc_low_ff} != crc_ff) begin
                        job_o.status = STAT_CRC_ERR;
                     end else if (!header_good_in) begin
                        job_o.status = STAT_HDR_ERR;
                     end else begin
                        job_o.status = STAT_OK;
                     end
                  end else begin
                     job_o.mode = JOB_REPLY;
                  end
               end
            end
            OP_TICK: begin
               if (waiting_ff) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= cfg_i.timeout_ticks) begin
                     waiting_in   = 1'b0;
                     job_valid_o  = 1'b1;
                     job_o.status = STAT_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // transaction state
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff     <= 1'b0;
         crc_ff         <= CRC_INIT;
         count_ff       <= 8'h00;
         crc_low_ff     <= 8'h00;
         header_good_ff <= 1'b1;
         elapsed_ff     <= 20'h00000;
         frame_ff       <= 8'h00;
      end else begin
         waiting_ff     <= waiting_in;
         crc_ff         <= crc_in;
         count_ff       <= count_in;
         crc_low_ff     <= crc_low_in;
         header_good_ff <= header_good_in;
         elapsed_ff     <= elapsed_in;
         frame_ff       <= frame_in;
      end
   end

endmodule

>>> rtl/mrhm_out.sv
// result register and emitter: plays out request frames byte by byte with
// the request crc built one byte per handoff; depends on mrhm_pkg
module mrhm_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_i,
   input  logic              job_valid_i,
   input  mrhm_pkg::job_type job_i,
   output logic              free_o,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_data_byte,
   output logic [7:0]        rsp_byte_index,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);
   import mrhm_pkg::*;

   logic        valid_ff, valid_in;
   job_type     job_ff, job_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        handoff;

   // result fields for the current position
   always_comb begin
      rsp_kind       = KIND_STATUS;
      rsp_data_byte  = 8'h00;
      rsp_byte_index = 8'h00;
      rsp_status     = STAT_OK;
      rsp_last       = 1'b1;
      case (job_ff.mode)
         JOB_REQUEST: begin
            rsp_kind       = KIND_REQUEST;
            rsp_byte_index = {5'd0, pos_ff};
            rsp_last       = (pos_ff == 3'd7);
            case (pos_ff)
               3'd0:    rsp_data_byte = job_ff.slave_address;
               3'd1:    rsp_data_byte = FUNC_READ_HOLDING;
               3'd2:    rsp_data_byte = job_ff.first_register[15:8];
               3'd3:    rsp_data_byte = job_ff.first_register[7:0];
               3'd4:    rsp_data_byte = 8'h00;
               3'd5:    rsp_data_byte = {1'b0, job_ff.register_count};
               3'd6:    rsp_data_byte = crc_ff[7:0];
               default: rsp_data_byte = crc_ff[15:8];
            endcase
         end
         JOB_REPLY: begin
            rsp_kind       = KIND_REPLY;
            rsp_data_byte  = job_ff.data;
            rsp_byte_index = job_ff.index;
         end
         JOB_REPLY_STATUS: begin
            if (pos_ff == 3'd0) begin
               rsp_kind       = KIND_REPLY;
               rsp_data_byte  = job_ff.data;
               rsp_byte_index = job_ff.index;
               rsp_last       = 1'b0;
            end else begin
               rsp_status = job_ff.status;
            end
         end
         default: begin
            rsp_status = job_ff.status;
         end
      endcase
   end

   assign rsp_valid = valid_ff;
   assign handoff   = valid_ff & rsp_ready;
   assign free_o    = !valid_ff || (rsp_ready && rsp_last);

   // load a new job or step through the current one
   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      if (load_i) begin
         valid_in = job_valid_i;
         job_in   = job_i;
         pos_in   = 3'd0;
         crc_in   = CRC_INIT;
      end else if (handoff) begin
         if (rsp_last) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
            if ((job_ff.mode == JOB_REQUEST) && (pos_ff < 3'd6)) begin
               crc_in = crc_byte(crc_ff, rsp_data_byte);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 3'd0;
         crc_ff   <= CRC_INIT;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

>>> rtl/modbus_rtu_read_holding_master.sv
// modbus rtu read-holding-registers master: takes one item per cycle while
// free; its first result is valid the cycle after it is taken. a start item
// gives eight request bytes (a status if too big), one per handoff, and holds
// off later items until the last is taken; others give at most two results.
// reset is synchronous and active high: idle, registers at their defaults.
module modbus_rtu_read_holding_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import mrhm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type job;
   logic    job_valid;
   logic    accept;
   logic    free;

   assign req_ready = free;
   assign accept    = req_valid & free;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:     cfg_in.slave_address     = csr_wdata[7:0];
            CSR_FIRST_REGISTER:    cfg_in.first_register    = csr_wdata[15:0];
            CSR_REGISTER_COUNT:    cfg_in.register_count    = csr_wdata[6:0];
            CSR_RESPONSE_CAPACITY: cfg_in.response_capacity = csr_wdata[7:0];
            CSR_TIMEOUT_TICKS:     cfg_in.timeout_ticks     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address     <= 8'd1;
         cfg_ff.first_register    <= 16'd0;
         cfg_ff.register_count    <= 7'd1;
         cfg_ff.response_capacity <= 8'd255;
         cfg_ff.timeout_ticks     <= 20'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // transaction tracking
   mrhm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept_i    (accept),
      .op_i        (req_op),
      .rx_byte_i   (req_rx_byte),
      .cfg_i       (cfg_ff),
      .job_valid_o (job_valid),
      .job_o       (job)
   );

   // result emitter
   mrhm_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load_i         (accept),
      .job_valid_i    (job_valid),
      .job_i          (job),
      .free_o         (free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule
